// ----- hdl/gbes_pkg.sv -----
// Shared types, codes and helpers for the gravity body stepper.
`timescale 1ns / 1ps
package gbes_pkg;

  localparam int ACC_W = 114;
  localparam int R2_W = 66;
  localparam int ROOT_W = 33;
  localparam int SREM_W = 36;
  localparam int DEN_W = 98;
  localparam int KB_W = 56;
  localparam int K_W = 80;
  localparam int Q_W = 31;
  localparam int STEP_W = 6;
  localparam int SQRT_LAST = 32;
  localparam int DIV_LAST = 31;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_STEP = 1'b1;

  localparam logic [1:0] REG_SOURCE_COUNT = 2'd0;
  localparam logic [1:0] REG_TIME_STEP = 2'd1;
  localparam logic [1:0] REG_GRAVITY = 2'd2;
  localparam logic [1:0] REG_UNMAPPED = 2'd3;

  localparam logic [15:0] TIME_STEP_RST = 16'd1092;
  localparam logic [31:0] GRAVITY_RST = 32'd65536;

  typedef enum logic [17:0] {
    ST_IDLE  = 18'b000000000000000001,
    ST_BINIT = 18'b000000000000000010,
    ST_NEXT  = 18'b000000000000000100,
    ST_DIFF  = 18'b000000000000001000,
    ST_SQ    = 18'b000000000000010000,
    ST_SQRT  = 18'b000000000000100000,
    ST_DEN   = 18'b000000000001000000,
    ST_KM    = 18'b000000000010000000,
    ST_NUMX  = 18'b000000000100000000,
    ST_DIVX  = 18'b000000001000000000,
    ST_NUMY  = 18'b000000010000000000,
    ST_DIVY  = 18'b000000100000000000,
    ST_FORCE = 18'b000001000000000000,
    ST_VX    = 18'b000010000000000000,
    ST_VY    = 18'b000100000000000000,
    ST_PX    = 18'b001000000000000000,
    ST_PY    = 18'b010000000000000000,
    ST_DONE  = 18'b100000000000000000
  } state_t;

  // clamp a 33-bit signed sum to 32 bits; top bit of the result is the clip flag
  function automatic logic [32:0] clamp33(input logic signed [32:0] v);
    logic [32:0] r;
    if (v[32] != v[31]) begin
      r = v[32] ? {1'b1, 32'h80000000} : {1'b1, 32'h7FFFFFFF};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

endpackage

// ----- hdl/gravity_body_euler_step_core.sv -----
// Point-gravity body stepper: source table, shared multiplier, sqrt and divide sequencer.
// A step request walks the source table; a source at zero distance is skipped, and any other goes
//   through square, sqrt, divisor, scale and two divisions, a clipped division ending early.
// Requests are taken one at a time: s_tready is high only in idle, and a load writes the table then.
// Reset (rst, synchronous): returns to idle, source_count 0, time_step 1092,
//   gravity_strength 65536; the source table keeps its contents.
`timescale 1ns / 1ps
module gravity_body_euler_step_core #(
  parameter int MAX_SOURCES = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // slot[3:0], pos_x[35:4], pos_y[67:36], vel_x[99:68], vel_y[131:100],
  // body_mass[155:132], zero pad
  input  logic [159:0] s_tdata,
  input  logic         s_tuser,  // kind
  input  logic         s_tlast,  // end_of_tick
  output logic         m_tvalid,
  input  logic         m_tready,
  // new_pos_x[31:0], new_pos_y[63:32], new_vel_x[95:64], new_vel_y[127:96]
  output logic [127:0] m_tdata,
  output logic         m_tuser,  // saturated
  output logic         m_tlast,  // tick_done
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  localparam int IW = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
  localparam int CW = $clog2(MAX_SOURCES + 1);
  localparam int FW = 33 + $clog2(MAX_SOURCES);
  localparam logic signed [FW-1:0] F_MAX = FW'(64'sd2147483647);
  localparam logic signed [FW-1:0] F_MIN = FW'(-64'sd2147483648);

  gbes_pkg::state_t state;

  logic [4:0]  source_count;
  logic [15:0] time_step;
  logic [31:0] gravity_strength;

  logic [31:0] mem_x [0:MAX_SOURCES-1];
  logic [31:0] mem_y [0:MAX_SOURCES-1];
  logic [23:0] mem_m [0:MAX_SOURCES-1];
  logic [31:0] sxr, syr;
  logic [23:0] smr;

  logic [CW-1:0] idx, n_src;
  logic [IW+3:0] slot_w;
  logic          slot_ok;

  logic signed [31:0] bx, by, vx, vy;
  logic [23:0] mbody;
  logic        tick, sat;
  logic signed [FW-1:0] fx, fy;
  logic signed [31:0] fxc, fyc;

  logic [32:0] adx, ady;
  logic        negx, negy;
  logic signed [32:0] dxs, dys;

  logic signed [34:0] ma, mb;
  logic signed [69:0] prod_r;
  logic [1:0]  part, last, sh;
  logic        ph, is_mul, mul_done;
  logic [gbes_pkg::ACC_W-1:0] acc, acc_next, prod_sh;

  logic [gbes_pkg::KB_W-1:0]   kb;
  logic [gbes_pkg::K_W-1:0]    k;
  logic [gbes_pkg::R2_W-1:0]   r2, sqv;
  logic [gbes_pkg::ROOT_W-1:0] root;
  logic [gbes_pkg::SREM_W-1:0] srem;
  logic [gbes_pkg::SREM_W+1:0] sq_t, sq_trial;
  logic [gbes_pkg::DEN_W-1:0]  den, work;
  logic [gbes_pkg::DEN_W:0]    div_t;
  logic        div_ge, div_fin, div_neg;
  logic [gbes_pkg::DEN_W-1:0]  div_rem;
  logic [gbes_pkg::Q_W-1:0]    q, qn, lowb, div_mag;
  logic [FW-1:0] c_mag;
  logic signed [FW-1:0] contrib;
  logic [gbes_pkg::STEP_W-1:0] step;
  logic signed [32:0] vsum;
  logic [32:0] vclamp;

  assign s_tready  = (state == gbes_pkg::ST_IDLE) && !rst;
  assign cfg_ready = !rst;

  always_comb begin
    if ({3'b0, source_count} >= 8'(MAX_SOURCES)) begin
      n_src = CW'(MAX_SOURCES);
    end else begin
      n_src = CW'(source_count);
    end
  end

  assign slot_w  = (IW + 4)'(s_tdata[3:0]);
  assign slot_ok = ({28'b0, s_tdata[3:0]} < 32'(MAX_SOURCES));

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready && s_tuser == gbes_pkg::KIND_LOAD && slot_ok) begin
      mem_x[slot_w[IW-1:0]] <= s_tdata[35:4];
      mem_y[slot_w[IW-1:0]] <= s_tdata[67:36];
      mem_m[slot_w[IW-1:0]] <= s_tdata[155:132];
    end
    sxr <= mem_x[idx[IW-1:0]];
    syr <= mem_y[idx[IW-1:0]];
    smr <= mem_m[idx[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      source_count     <= 5'd0;
      time_step        <= gbes_pkg::TIME_STEP_RST;
      gravity_strength <= gbes_pkg::GRAVITY_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        gbes_pkg::REG_SOURCE_COUNT: source_count <= cfg_data[4:0];
        gbes_pkg::REG_TIME_STEP:    time_step <= cfg_data[15:0];
        gbes_pkg::REG_GRAVITY:      gravity_strength <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    is_mul = state inside {gbes_pkg::ST_BINIT, gbes_pkg::ST_SQ, gbes_pkg::ST_DEN,
                           gbes_pkg::ST_KM, gbes_pkg::ST_NUMX, gbes_pkg::ST_NUMY,
                           gbes_pkg::ST_VX, gbes_pkg::ST_VY, gbes_pkg::ST_PX,
                           gbes_pkg::ST_PY};
  end

  always_comb begin
    ma   = '0;
    mb   = '0;
    sh   = 2'd0;
    last = 2'd0;
    case (state)
      gbes_pkg::ST_BINIT: begin
        ma = {3'b0, gravity_strength};
        mb = {11'b0, mbody};
      end
      gbes_pkg::ST_SQ: begin
        last = 2'd1;
        ma = (part == 2'd0) ? {2'b0, adx} : {2'b0, ady};
        mb = ma;
      end
      gbes_pkg::ST_DEN: begin
        last = 2'd1;
        sh = part;
        ma = (part == 2'd0) ? {1'b0, r2[33:0]} : {3'b0, r2[65:34]};
        mb = {2'b0, root};
      end
      gbes_pkg::ST_KM: begin
        last = 2'd1;
        sh = part;
        ma = (part == 2'd0) ? {1'b0, kb[33:0]} : {13'b0, kb[55:34]};
        mb = {11'b0, smr};
      end
      gbes_pkg::ST_NUMX, gbes_pkg::ST_NUMY: begin
        last = 2'd2;
        sh = part;
        case (part)
          2'd0:    ma = {1'b0, k[33:0]};
          2'd1:    ma = {1'b0, k[67:34]};
          default: ma = {23'b0, k[79:68]};
        endcase
        mb = (state == gbes_pkg::ST_NUMX) ? {2'b0, adx} : {2'b0, ady};
      end
      gbes_pkg::ST_VX: begin
        ma = {{3{fxc[31]}}, fxc};
        mb = {19'b0, time_step};
      end
      gbes_pkg::ST_VY: begin
        ma = {{3{fyc[31]}}, fyc};
        mb = {19'b0, time_step};
      end
      gbes_pkg::ST_PX: begin
        ma = {{3{vx[31]}}, vx};
        mb = {19'b0, time_step};
      end
      gbes_pkg::ST_PY: begin
        ma = {{3{vy[31]}}, vy};
        mb = {19'b0, time_step};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= ma * mb;
  end

  always_comb begin
    case (sh)
      2'd0:    prod_sh = gbes_pkg::ACC_W'(prod_r[67:0]);
      2'd1:    prod_sh = gbes_pkg::ACC_W'(prod_r[67:0]) << 34;
      default: prod_sh = gbes_pkg::ACC_W'(prod_r[67:0]) << 68;
    endcase
    acc_next = ((part == 2'd0) ? '0 : acc) + prod_sh;
  end

  assign mul_done = is_mul && ph && (part == last);

  always_ff @(posedge clk) begin
    if (rst) begin
      ph   <= 1'b0;
      part <= 2'd0;
    end else if (is_mul) begin
      if (!ph) begin
        ph <= 1'b1;
      end else begin
        ph   <= 1'b0;
        part <= (part == last) ? 2'd0 : part + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (is_mul && ph) begin
      acc <= acc_next;
    end
  end

  assign dxs = $signed({sxr[31], sxr}) - $signed({bx[31], bx});
  assign dys = $signed({syr[31], syr}) - $signed({by[31], by});

  assign sq_t     = {srem, sqv[65:64]};
  assign sq_trial = {3'b0, root, 2'b01};

  assign div_t   = {work, lowb[30]};
  assign div_ge  = (div_t >= {1'b0, den});
  assign div_rem = div_ge ? gbes_pkg::DEN_W'(div_t - {1'b0, den}) : div_t[97:0];
  assign qn      = {q[29:0], div_ge};
  assign div_mag = (step == '0) ? 31'h7FFFFFFF : qn;
  assign div_fin = (step == '0) ? (work >= den) : (step == gbes_pkg::STEP_W'(gbes_pkg::DIV_LAST));
  assign div_neg = (state == gbes_pkg::ST_DIVX) ? negx : negy;
  assign c_mag   = FW'(div_mag);
  assign contrib = div_neg ? -$signed(c_mag) : $signed(c_mag);

  always_comb begin
    if (state == gbes_pkg::ST_VX || state == gbes_pkg::ST_PX) begin
      vsum = (state == gbes_pkg::ST_VX) ? $signed({vx[31], vx}) : $signed({bx[31], bx});
    end else begin
      vsum = (state == gbes_pkg::ST_VY) ? $signed({vy[31], vy}) : $signed({by[31], by});
    end
    vsum   = vsum + $signed({prod_r[47], prod_r[47:16]});
    vclamp = gbes_pkg::clamp33(vsum);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gbes_pkg::ST_IDLE;
      idx   <= '0;
    end else begin
      case (state)
        gbes_pkg::ST_IDLE: begin
          if (s_tvalid && s_tuser == gbes_pkg::KIND_STEP) begin
            bx    <= s_tdata[35:4];
            by    <= s_tdata[67:36];
            vx    <= s_tdata[99:68];
            vy    <= s_tdata[131:100];
            mbody <= s_tdata[155:132];
            tick  <= s_tlast;
            sat   <= 1'b0;
            fx    <= '0;
            fy    <= '0;
            idx   <= '0;
            state <= gbes_pkg::ST_BINIT;
          end
        end
        gbes_pkg::ST_BINIT: begin
          if (mul_done) begin
            kb    <= acc_next[55:0];
            state <= gbes_pkg::ST_NEXT;
          end
        end
        gbes_pkg::ST_NEXT: begin
          state <= (idx == n_src) ? gbes_pkg::ST_FORCE : gbes_pkg::ST_DIFF;
        end
        gbes_pkg::ST_DIFF: begin
          negx <= dxs[32];
          negy <= dys[32];
          adx  <= dxs[32] ? 33'(-dxs) : dxs;
          ady  <= dys[32] ? 33'(-dys) : dys;
          if (dxs == '0 && dys == '0) begin
            idx   <= idx + CW'(1);
            state <= gbes_pkg::ST_NEXT;
          end else begin
            state <= gbes_pkg::ST_SQ;
          end
        end
        gbes_pkg::ST_SQ: begin
          if (mul_done) begin
            r2    <= acc_next[65:0];
            sqv   <= acc_next[65:0];
            srem  <= '0;
            root  <= '0;
            step  <= '0;
            state <= gbes_pkg::ST_SQRT;
          end
        end
        gbes_pkg::ST_SQRT: begin
          if (sq_t >= sq_trial) begin
            srem <= gbes_pkg::SREM_W'(sq_t - sq_trial);
            root <= {root[31:0], 1'b1};
          end else begin
            srem <= sq_t[35:0];
            root <= {root[31:0], 1'b0};
          end
          sqv  <= sqv << 2;
          step <= step + gbes_pkg::STEP_W'(1);
          if (step == gbes_pkg::STEP_W'(gbes_pkg::SQRT_LAST)) begin
            state <= gbes_pkg::ST_DEN;
          end
        end
        gbes_pkg::ST_DEN: begin
          if (mul_done) begin
            den   <= acc_next[97:0];
            state <= gbes_pkg::ST_KM;
          end
        end
        gbes_pkg::ST_KM: begin
          if (mul_done) begin
            k     <= acc_next[79:0];
            state <= gbes_pkg::ST_NUMX;
          end
        end
        gbes_pkg::ST_NUMX, gbes_pkg::ST_NUMY: begin
          if (mul_done) begin
            work  <= acc_next[112:15];
            lowb  <= {acc_next[14:0], 16'b0};
            step  <= '0;
            state <= (state == gbes_pkg::ST_NUMX) ? gbes_pkg::ST_DIVX : gbes_pkg::ST_DIVY;
          end
        end
        gbes_pkg::ST_DIVX, gbes_pkg::ST_DIVY: begin
          if (step != '0) begin
            work <= div_rem;
            q    <= qn;
            lowb <= lowb << 1;
          end
          step <= step + gbes_pkg::STEP_W'(1);
          if (div_fin) begin
            if (step == '0) begin
              sat <= 1'b1;
            end
            if (state == gbes_pkg::ST_DIVX) begin
              fx    <= fx + contrib;
              state <= gbes_pkg::ST_NUMY;
            end else begin
              fy    <= fy + contrib;
              idx   <= idx + CW'(1);
              state <= gbes_pkg::ST_NEXT;
            end
          end
        end
        gbes_pkg::ST_FORCE: begin
          if (fx > F_MAX) begin
            fxc <= 32'sh7FFFFFFF;
          end else if (fx < F_MIN) begin
            fxc <= 32'sh80000000;
          end else begin
            fxc <= fx[31:0];
          end
          if (fy > F_MAX) begin
            fyc <= 32'sh7FFFFFFF;
          end else if (fy < F_MIN) begin
            fyc <= 32'sh80000000;
          end else begin
            fyc <= fy[31:0];
          end
          if (fx > F_MAX || fx < F_MIN || fy > F_MAX || fy < F_MIN) begin
            sat <= 1'b1;
          end
          state <= gbes_pkg::ST_VX;
        end
        gbes_pkg::ST_VX: begin
          if (mul_done) begin
            vx    <= vclamp[31:0];
            sat   <= sat | vclamp[32];
            state <= gbes_pkg::ST_VY;
          end
        end
        gbes_pkg::ST_VY: begin
          if (mul_done) begin
            vy    <= vclamp[31:0];
            sat   <= sat | vclamp[32];
            state <= gbes_pkg::ST_PX;
          end
        end
        gbes_pkg::ST_PX: begin
          if (mul_done) begin
            bx    <= vclamp[31:0];
            sat   <= sat | vclamp[32];
            state <= gbes_pkg::ST_PY;
          end
        end
        gbes_pkg::ST_PY: begin
          if (mul_done) begin
            by    <= vclamp[31:0];
            sat   <= sat | vclamp[32];
            state <= gbes_pkg::ST_DONE;
          end
        end
        gbes_pkg::ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            state <= gbes_pkg::ST_IDLE;
          end
        end
        default: state <= gbes_pkg::ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == gbes_pkg::ST_DONE && (!m_tvalid || m_tready)) begin
      m_tdata <= {vy, vx, by, bx};
      m_tuser <= sat;
      m_tlast <= tick;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == gbes_pkg::ST_DONE && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

`ifndef ASSERT_OFF
  a_div_rem_below_den: assert property (@(posedge clk) disable iff (rst)
    ((state == gbes_pkg::ST_DIVX || state == gbes_pkg::ST_DIVY) && step != '0)
      |-> (work < den))
    else $error("division remainder not below divisor");

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == gbes_pkg::ST_NEXT) |-> (idx <= n_src))
    else $error("source index beyond source count");

  a_part_in_range: assert property (@(posedge clk) disable iff (rst)
    (state != gbes_pkg::ST_NUMX && state != gbes_pkg::ST_NUMY) |-> (part != 2'd2))
    else $error("multiply chunk beyond last");

  a_step_starts: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser == gbes_pkg::KIND_STEP) |=> (state == gbes_pkg::ST_BINIT))
    else $error("step request did not start sequence");
`endif

endmodule
